// ===== sv/bdcp_pkg.sv =====
`timescale 1ns / 1ps
package bdcp_pkg;

  localparam int PointDepth = 16;
  localparam int KnotDepth  = 32;
  localparam int MaxWindow  = 8;

  localparam int InW    = 32;  // Q16.16 coordinates and knots
  localparam int OutW   = 48;  // Q32.16 results
  localparam int DiffW  = OutW + 1;
  localparam int FacW   = 5;
  localparam int NumW   = DiffW + FacW;  // scaled difference
  localparam int DenW   = InW + 1;       // knot difference
  localparam int FracW  = 16;

  // Request operation codes.
  localparam logic [1:0] OP_LOAD_POINT = 2'd0;
  localparam logic [1:0] OP_LOAD_KNOT  = 2'd1;
  localparam logic [1:0] OP_COMPUTE    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEGREE     = 2'd0;
  localparam logic [1:0] CFG_DERIV      = 2'd1;
  localparam logic [1:0] CFG_FIRST      = 2'd2;
  localparam logic [1:0] CFG_LAST       = 2'd3;

  typedef logic signed [OutW-1:0] coord_t;

endpackage

// ===== sv/bspline_derivative_control_points.sv =====
`timescale 1ns / 1ps
// Point and knot loads leave busy low. A compute request emits each row 0
// entry straight from the point store and each derivative entry from the
// 70-step serial dividers (one per coordinate, run side by side); an entry
// with a zero knot span skips the dividers. Results appear one per strobe
// on out_valid and cannot be held off; a rejected window gives a single
// result flagged range_error. Store entries never written read as undefined
// values.
module bspline_derivative_control_points (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_operation,
  input  logic [4:0]                 in_index,
  input  logic signed [31:0]         in_x_value,
  input  logic signed [31:0]         in_y_value,
  input  logic signed [31:0]         in_z_value,
  output logic                       out_valid,
  output logic [2:0]                 out_order,
  output logic [2:0]                 out_position,
  output logic signed [47:0]         out_x_out,
  output logic signed [47:0]         out_y_out,
  output logic signed [47:0]         out_z_out,
  output logic                       out_zero_span,
  output logic                       out_range_error,
  output logic                       out_last,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [3:0]                 cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_CP_RD, S_CP_WR, S_KA, S_KB, S_KC, S_KD, S_DIV
  } state_t;

  state_t state_r;
  logic [2:0] deg_r, dord_r, k_r, i_r, range_r, kmax_r;
  logic [3:0] first_r, last_r;

  // Stores.
  logic signed [31:0] pt_x_mem [bdcp_pkg::PointDepth];
  logic signed [31:0] pt_y_mem [bdcp_pkg::PointDepth];
  logic signed [31:0] pt_z_mem [bdcp_pkg::PointDepth];
  logic signed [31:0] kn_mem   [bdcp_pkg::KnotDepth];
  bdcp_pkg::coord_t   rb_x_mem [bdcp_pkg::MaxWindow];
  bdcp_pkg::coord_t   rb_y_mem [bdcp_pkg::MaxWindow];
  bdcp_pkg::coord_t   rb_z_mem [bdcp_pkg::MaxWindow];

  logic signed [31:0] pt_x_r, pt_y_r, pt_z_r, kn_r, ka_r;
  bdcp_pkg::coord_t   rb_x_r, rb_y_r, rb_z_r, rb1_x_r, rb1_y_r, rb1_z_r;
  logic signed [bdcp_pkg::NumW-1:0] num_x_r, num_y_r, num_z_r;
  logic signed [bdcp_pkg::DenW-1:0] den_r;

  logic [4:0] kn_addr;
  logic [2:0] rb_addr;
  logic       accept;
  logic       div_start;
  logic       div_done, div_done_y, div_done_z;
  bdcp_pkg::coord_t q_x, q_y, q_z;

  logic       emit, emit_zs, is_last, adv;
  bdcp_pkg::coord_t e_x, e_y, e_z;
  logic signed [bdcp_pkg::DenW-1:0] den_c;
  logic signed [bdcp_pkg::FacW-1:0] fac;
  logic signed [bdcp_pkg::DiffW-1:0] d_x, d_y, d_z;
  logic [3:0] last_pos;
  logic       bad_win;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // Point and knot loads.
  always_ff @(posedge clk) begin
    if (accept && in_operation == bdcp_pkg::OP_LOAD_POINT && !in_index[4]) begin
      pt_x_mem[in_index[3:0]] <= in_x_value;
      pt_y_mem[in_index[3:0]] <= in_y_value;
      pt_z_mem[in_index[3:0]] <= in_z_value;
    end
    if (accept && in_operation == bdcp_pkg::OP_LOAD_KNOT) begin
      kn_mem[in_index] <= in_x_value;
    end
  end

  // Read addresses follow the sequencer step.
  always_comb begin
    kn_addr = (state_r == S_KA) ? 5'(first_r) + 5'(i_r) + 5'(deg_r) + 5'd1
                                : 5'(first_r) + 5'(i_r) + 5'(k_r);
    rb_addr = (state_r == S_KA) ? 3'(i_r + 3'd1) : i_r;
  end

  // Registered reads.
  always_ff @(posedge clk) begin
    pt_x_r <= pt_x_mem[4'(first_r + 4'(i_r))];
    pt_y_r <= pt_y_mem[4'(first_r + 4'(i_r))];
    pt_z_r <= pt_z_mem[4'(first_r + 4'(i_r))];
    kn_r   <= kn_mem[kn_addr];
    rb_x_r <= rb_x_mem[rb_addr];
    rb_y_r <= rb_y_mem[rb_addr];
    rb_z_r <= rb_z_mem[rb_addr];
  end

  // Entry result selection and row buffer write-back.
  always_comb begin
    den_c    = {ka_r[31], ka_r} - {kn_r[31], kn_r};
    last_pos = 4'(i_r) + 4'(k_r);
    is_last  = (k_r == kmax_r) && (last_pos == 4'(range_r));
    emit     = 1'b0;
    emit_zs  = 1'b0;
    e_x      = '0;
    e_y      = '0;
    e_z      = '0;
    case (state_r)
      S_CP_WR: begin
        emit = 1'b1;
        e_x  = bdcp_pkg::coord_t'(pt_x_r);
        e_y  = bdcp_pkg::coord_t'(pt_y_r);
        e_z  = bdcp_pkg::coord_t'(pt_z_r);
      end
      S_KC: begin
        if (den_c == '0) begin
          emit    = 1'b1;
          emit_zs = 1'b1;
        end
      end
      S_DIV: begin
        // The three dividers start together and finish together.
        if (div_done && div_done_y && div_done_z) begin
          emit = 1'b1;
          e_x  = q_x;
          e_y  = q_y;
          e_z  = q_z;
        end
      end
      default: ;
    endcase
    adv = emit;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rb_x_mem[i_r] <= e_x;
      rb_y_mem[i_r] <= e_y;
      rb_z_mem[i_r] <= e_z;
    end
  end

  // Scaled neighbor differences, registered ahead of the dividers.
  always_comb begin
    fac = bdcp_pkg::FacW'({2'b00, deg_r}) - bdcp_pkg::FacW'({2'b00, k_r})
          + bdcp_pkg::FacW'(1);
    d_x = bdcp_pkg::DiffW'(rb1_x_r) - bdcp_pkg::DiffW'(rb_x_r);
    d_y = bdcp_pkg::DiffW'(rb1_y_r) - bdcp_pkg::DiffW'(rb_y_r);
    d_z = bdcp_pkg::DiffW'(rb1_z_r) - bdcp_pkg::DiffW'(rb_z_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_KB) begin
      ka_r    <= kn_r;
      rb1_x_r <= rb_x_r;
      rb1_y_r <= rb_y_r;
      rb1_z_r <= rb_z_r;
    end
    if (state_r == S_KC) begin
      den_r   <= den_c;
      num_x_r <= d_x * fac;
      num_y_r <= d_y * fac;
      num_z_r <= d_z * fac;
    end
  end

  assign div_start = (state_r == S_KD);
  assign bad_win   = (last_r < first_r) ||
                     ((5'(last_r) - 5'(first_r)) >= 5'(bdcp_pkg::MaxWindow));

  bdcp_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_x_r), .den(den_r),
    .done(div_done), .quo(q_x)
  );
  bdcp_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_y_r), .den(den_r),
    .done(div_done_y), .quo(q_y)
  );
  bdcp_div u_div_z (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_z_r), .den(den_r),
    .done(div_done_z), .quo(q_z)
  );

  // Sequencer, configuration and registered results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      deg_r     <= 3'd3;
      dord_r    <= 3'd1;
      first_r   <= 4'd0;
      last_r    <= 4'd3;
      out_valid <= 1'b0;
      k_r       <= '0;
      i_r       <= '0;
      range_r   <= '0;
      kmax_r    <= '0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          bdcp_pkg::CFG_DEGREE: deg_r   <= cfg_data[2:0];
          bdcp_pkg::CFG_DERIV:  dord_r  <= cfg_data[2:0];
          bdcp_pkg::CFG_FIRST:  first_r <= cfg_data;
          bdcp_pkg::CFG_LAST:   last_r  <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept && in_operation == bdcp_pkg::OP_COMPUTE) begin
            if (bad_win) begin
              out_valid       <= 1'b1;
              out_order       <= '0;
              out_position    <= '0;
              out_x_out       <= '0;
              out_y_out       <= '0;
              out_z_out       <= '0;
              out_zero_span   <= 1'b0;
              out_range_error <= 1'b1;
              out_last        <= 1'b1;
            end else begin
              range_r <= 3'(last_r - first_r);
              kmax_r  <= (dord_r < 3'(last_r - first_r)) ? dord_r
                                                          : 3'(last_r - first_r);
              k_r     <= '0;
              i_r     <= '0;
              state_r <= S_CP_RD;
            end
          end
        end
        S_CP_RD: state_r <= S_CP_WR;
        S_KA:    state_r <= S_KB;
        S_KB:    state_r <= S_KC;
        S_KD:    state_r <= S_DIV;
        default: begin
          if (state_r == S_KC && !adv) begin
            state_r <= S_KD;
          end
        end
      endcase
      if (adv) begin
        out_valid       <= 1'b1;
        out_order       <= k_r;
        out_position    <= i_r;
        out_x_out       <= e_x;
        out_y_out       <= e_y;
        out_z_out       <= e_z;
        out_zero_span   <= emit_zs;
        out_range_error <= 1'b0;
        out_last        <= is_last;
        if (is_last) begin
          state_r <= S_IDLE;
        end else if (k_r == '0 && i_r != range_r) begin
          i_r     <= i_r + 3'd1;
          state_r <= S_CP_RD;
        end else if (last_pos == 4'(range_r)) begin
          k_r     <= k_r + 3'd1;
          i_r     <= '0;
          state_r <= S_KA;
        end else begin
          i_r     <= i_r + 3'd1;
          state_r <= S_KA;
        end
      end
    end
  end

endmodule

// ===== sv/bdcp_div.sv =====
`timescale 1ns / 1ps
// Serial signed fixed-point divider: (num << 16) / den, truncated toward
// zero and saturated to the signed result range. One quotient bit a cycle.
module bdcp_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [bdcp_pkg::NumW-1:0]       num,
  input  logic signed [bdcp_pkg::DenW-1:0]       den,
  output logic                                   done,
  output bdcp_pkg::coord_t                       quo
);

  localparam int Steps = bdcp_pkg::NumW + bdcp_pkg::FracW;
  localparam int CntW  = $clog2(Steps + 1);
  localparam int OW    = bdcp_pkg::OutW;

  typedef logic signed [OW-1:0] coord_t_local;

  logic [bdcp_pkg::NumW-1:0] dv_r;
  logic [bdcp_pkg::DenW-1:0] ud_r;
  logic [bdcp_pkg::DenW:0]   rem_r;
  logic [OW-1:0]             q_r;
  logic                      ovf_r;
  logic                      neg_r;
  logic [CntW-1:0]           cnt_r;
  logic                      run_r;
  logic                      done_r;
  coord_t_local              quo_r;

  logic [bdcp_pkg::DenW:0] trial;
  logic                    fits;
  logic [OW-1:0]           limit;
  logic [OW-1:0]           q_fin;
  logic                    qbit;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial = {rem_r[bdcp_pkg::DenW-1:0], dv_r[bdcp_pkg::NumW-1]};
    fits  = trial >= {1'b0, ud_r};
    qbit  = fits;
    limit = neg_r ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    q_fin = {q_r[OW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CntW'(Steps);
        neg_r <= num[bdcp_pkg::NumW-1] ^ den[bdcp_pkg::DenW-1];
        dv_r  <= num[bdcp_pkg::NumW-1] ? bdcp_pkg::NumW'(-num) : bdcp_pkg::NumW'(num);
        ud_r  <= den[bdcp_pkg::DenW-1] ? bdcp_pkg::DenW'(-den) : bdcp_pkg::DenW'(den);
        rem_r <= '0;
        q_r   <= '0;
        ovf_r <= 1'b0;
      end else if (run_r) begin
        dv_r  <= {dv_r[bdcp_pkg::NumW-2:0], 1'b0};
        rem_r <= fits ? trial - {1'b0, ud_r} : trial;
        q_r   <= q_fin;
        ovf_r <= ovf_r | q_r[OW-1];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
          // Saturate the magnitude, then restore the sign.
          if (ovf_r || q_r[OW-1] || (q_fin > limit)) begin
            quo_r <= neg_r ? coord_t_local'(-limit) : coord_t_local'(limit);
          end else begin
            quo_r <= neg_r ? coord_t_local'(-q_fin) : coord_t_local'(q_fin);
          end
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== sv/bdcp_chk.sv =====
`timescale 1ns / 1ps
module bdcp_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [1:0]          in_operation,
  input logic                out_valid,
  input logic signed [47:0]  out_x_out,
  input logic signed [47:0]  out_y_out,
  input logic signed [47:0]  out_z_out,
  input logic                out_zero_span,
  input logic                out_range_error,
  input logic                out_last
);

  // A rejected window is always the one and final result.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_last)
    else $error("range error result not marked last");

  // Loads never make the block busy.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation != bdcp_pkg::OP_COMPUTE |=> !busy)
    else $error("load request left block busy");

  // The final result of a request frees the block.
  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("busy after final result");

  // A zero knot span forces a zero entry.
  a_zero_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_span |->
      out_x_out == '0 && out_y_out == '0 && out_z_out == '0)
    else $error("zero span entry not zero");

endmodule

bind bspline_derivative_control_points bdcp_chk u_bdcp_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_operation(in_operation), .out_valid(out_valid),
  .out_x_out(out_x_out), .out_y_out(out_y_out), .out_z_out(out_z_out),
  .out_zero_span(out_zero_span), .out_range_error(out_range_error),
  .out_last(out_last)
);

// ===== verif/tb_bspline_derivative_control_points.sv =====
`timescale 1ns / 1ps
module tb_bspline_derivative_control_points;

  // Operation code that the block ignores.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // One table entry as the block reports it.
  typedef struct packed {
    logic [2:0]    order;
    logic [2:0]    position;
    logic [47:0]   x;
    logic [47:0]   y;
    logic [47:0]   z;
    logic          zero_span;
    logic          range_error;
    logic          last;
  } entry_t;

  int error_count;
  int request_count;
  int entry_count;

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    error_count++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // Scoreboard: shadows the stores and registers and queues expected entries.
  class table_scoreboard;
    logic signed [63:0] points[bdcp_pkg::PointDepth][3];
    logic signed [63:0] knots[bdcp_pkg::KnotDepth];
    logic signed [63:0] rows[bdcp_pkg::MaxWindow][3];
    logic [2:0] degree;
    logic [2:0] deriv_order;
    logic [3:0] first_pt;
    logic [3:0] last_pt;
    entry_t pending[$];

    function new();
      foreach (points[i, c]) points[i][c] = 0;
      foreach (knots[i]) knots[i] = 0;
      foreach (rows[i, c]) rows[i][c] = 0;
      degree = 3;
      deriv_order = 1;
      first_pt = 0;
      last_pt = 3;
    endfunction

    function void write_reg(logic [1:0] idx, logic [3:0] val);
      case (idx)
        bdcp_pkg::CFG_DEGREE: degree = val[2:0];
        bdcp_pkg::CFG_DERIV:  deriv_order = val[2:0];
        bdcp_pkg::CFG_FIRST:  first_pt = val;
        bdcp_pkg::CFG_LAST:   last_pt = val;
        default: ;
      endcase
    endfunction

    // (num << 16) / den truncated toward zero, saturated to 48 bits.
    function logic signed [63:0] scaled_quotient(logic signed [63:0] num,
                                                 logic signed [63:0] den);
      logic negative;
      logic [63:0] un;
      logic [63:0] ud;
      logic [63:0] lim;
      logic [63:0] qh;
      logic [63:0] rem;
      logic [63:0] mag;
      negative = (num < 0) != (den < 0);
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      lim = negative ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
      qh = un / ud;
      rem = un % ud;
      if (qh > (lim >> 16)) begin
        mag = lim;
      end else begin
        mag = (qh << 16) + ((rem << 16) / ud);
        if (mag > lim) mag = lim;
      end
      return negative ? -$signed(mag) : $signed(mag);
    endfunction

    function logic signed [63:0] knot_at(int idx);
      return (idx < bdcp_pkg::KnotDepth) ? knots[idx] : 0;
    endfunction

    function void push_entry(int k, int i, logic signed [63:0] c[3],
                             logic zs, logic re, logic lst);
      entry_t e;
      e.order = k[2:0];
      e.position = i[2:0];
      e.x = c[0][47:0];
      e.y = c[1][47:0];
      e.z = c[2][47:0];
      e.zero_span = zs;
      e.range_error = re;
      e.last = lst;
      pending.push_back(e);
    endfunction

    // Note one accepted request and queue the table entries it produces.
    function void note_request(logic [1:0] op, logic [4:0] idx,
                               logic signed [31:0] xv, logic signed [31:0] yv,
                               logic signed [31:0] zv);
      logic signed [63:0] zero3[3];
      logic signed [63:0] den;
      logic signed [63:0] factor;
      logic zs;
      int span;
      int kmax;
      zero3 = '{0, 0, 0};
      case (op)
        bdcp_pkg::OP_LOAD_POINT: begin
          if (idx < bdcp_pkg::PointDepth) begin
            points[idx][0] = xv;
            points[idx][1] = yv;
            points[idx][2] = zv;
          end
        end
        bdcp_pkg::OP_LOAD_KNOT: begin
          if (idx < bdcp_pkg::KnotDepth) knots[idx] = xv;
        end
        bdcp_pkg::OP_COMPUTE: begin
          if (last_pt < first_pt || last_pt - first_pt + 1 > bdcp_pkg::MaxWindow) begin
            push_entry(0, 0, zero3, 0, 1, 1);
          end else begin
            span = last_pt - first_pt;
            kmax = (deriv_order < span) ? deriv_order : span;
            for (int i = 0; i <= span; i++) begin
              for (int c = 0; c < 3; c++) rows[i][c] = points[first_pt + i][c];
              push_entry(0, i, rows[i], 0, 0, kmax == 0 && i == span);
            end
            for (int k = 1; k <= kmax; k++) begin
              factor = $signed({61'd0, degree}) - k + 1;
              for (int i = 0; i + k <= span; i++) begin
                den = knot_at(first_pt + i + degree + 1) - knot_at(first_pt + i + k);
                zs = (den == 0);
                for (int c = 0; c < 3; c++) begin
                  rows[i][c] = zs ? 64'sd0
                             : scaled_quotient(factor * (rows[i + 1][c] - rows[i][c]), den);
                end
                push_entry(k, i, rows[i], zs, 0, k == kmax && i + k == span);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result with the oldest expected entry.
    task check_entry(entry_t got);
      entry_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", got.x, 0);
        return;
      end
      want = pending.pop_front();
      if (got.order != want.order) report_mismatch("order", got.order, want.order);
      if (got.position != want.position)
        report_mismatch("position", got.position, want.position);
      if (got.x != want.x) report_mismatch("x_out", got.x, want.x);
      if (got.y != want.y) report_mismatch("y_out", got.y, want.y);
      if (got.z != want.z) report_mismatch("z_out", got.z, want.z);
      if (got.zero_span != want.zero_span)
        report_mismatch("zero_span", got.zero_span, want.zero_span);
      if (got.range_error != want.range_error)
        report_mismatch("range_error", got.range_error, want.range_error);
      if (got.last != want.last) report_mismatch("last", got.last, want.last);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_operation;
  logic [4:0] in_index;
  logic signed [31:0] in_x_value;
  logic signed [31:0] in_y_value;
  logic signed [31:0] in_z_value;
  logic out_valid;
  logic [2:0] out_order;
  logic [2:0] out_position;
  logic signed [47:0] out_x_out;
  logic signed [47:0] out_y_out;
  logic signed [47:0] out_z_out;
  logic out_zero_span;
  logic out_range_error;
  logic out_last;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  table_scoreboard sb;
  int sender_idle_pct;

  bspline_derivative_control_points u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_index(in_index),
    .in_x_value(in_x_value), .in_y_value(in_y_value), .in_z_value(in_z_value),
    .out_valid(out_valid), .out_order(out_order), .out_position(out_position),
    .out_x_out(out_x_out), .out_y_out(out_y_out), .out_z_out(out_z_out),
    .out_zero_span(out_zero_span), .out_range_error(out_range_error),
    .out_last(out_last), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Timeout at %0t", $realtime);
    $display("CHECKS FAILED");
    $finish;
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      entry_count++;
      sb.check_entry({out_order, out_position, out_x_out[47:0], out_y_out[47:0],
                      out_z_out[47:0], out_zero_span, out_range_error, out_last});
    end
  end

  // Issue one request and wait for it to be accepted. Start stays high after
  // the accepting edge until the next task drives it in the same time step.
  task automatic send_request(input logic [1:0] op, input logic [4:0] idx,
                              input logic [31:0] xv, input logic [31:0] yv,
                              input logic [31:0] zv);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_index <= idx;
    in_x_value <= xv;
    in_y_value <= yv;
    in_z_value <= zv;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(op, idx, xv, yv, zv);
    request_count++;
  endtask

  // Wait until every queued entry has come out and the block is quiet.
  task automatic drain();
    int guard;
    start <= 1'b0;
    cfg_we <= 1'b0;
    guard = 0;
    while ((sb.pending.size() != 0 || busy) && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_window(input int deg, input int ord, input int fp, input int lp);
    write_reg(bdcp_pkg::CFG_DEGREE, deg[3:0]);
    write_reg(bdcp_pkg::CFG_DERIV, ord[3:0]);
    write_reg(bdcp_pkg::CFG_FIRST, fp[3:0]);
    write_reg(bdcp_pkg::CFG_LAST, lp[3:0]);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      default: return $urandom;
    endcase
  endfunction

  // Random knot: often repeated values so zero spans arise.
  function automatic logic [31:0] rand_knot(int idx);
    case ($urandom_range(3))
      0: return 32'(idx) << 16;
      1: return 32'(idx / 2) << 16;
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Load every point and knot so that no compute reads an unwritten entry.
  task automatic fill_stores();
    for (int i = 0; i < bdcp_pkg::PointDepth; i++)
      send_request(bdcp_pkg::OP_LOAD_POINT, i[4:0], rand_coord(), rand_coord(),
                   rand_coord());
    for (int i = 0; i < bdcp_pkg::KnotDepth; i++)
      send_request(bdcp_pkg::OP_LOAD_KNOT, i[4:0], rand_knot(i), $urandom, $urandom);
  endtask

  initial begin
    int phase;
    int fp;
    int lp;
    int pick;
    sb = new();
    error_count = 0;
    request_count = 0;
    entry_count = 0;
    sender_idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = bdcp_pkg::OP_LOAD_POINT;
    in_index = '0;
    in_x_value = '0;
    in_y_value = '0;
    in_z_value = '0;
    cfg_we = 1'b0;
    cfg_index = bdcp_pkg::CFG_DEGREE;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extreme points and knots, reset window, bad windows.
    fill_stores();
    send_request(bdcp_pkg::OP_LOAD_POINT, 5'd16, 32'hFFFF_FFFF, 32'h0, 32'h1);
    send_request(OP_RESERVED, 5'd31, 32'h1234_5678, 32'h0, 32'h0);
    send_request(bdcp_pkg::OP_LOAD_POINT, 5'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_request(bdcp_pkg::OP_LOAD_POINT, 5'd1, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'hFFFF_FFFF);
    send_request(bdcp_pkg::OP_LOAD_KNOT, 5'd5, 32'h0004_0000, 32'h0, 32'h0);
    send_request(bdcp_pkg::OP_COMPUTE, 5'd0, 32'h0, 32'h0, 32'h0);
    drain();
    set_window(7, 7, 0, 7);
    send_request(bdcp_pkg::OP_LOAD_KNOT, 5'd8, 32'h8000_0000, 32'h0, 32'h0);
    send_request(bdcp_pkg::OP_LOAD_KNOT, 5'd1, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send_request(bdcp_pkg::OP_COMPUTE, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
    drain();
    set_window(1, 0, 15, 15);
    send_request(bdcp_pkg::OP_COMPUTE, 5'd0, 32'h0, 32'h0, 32'h0);
    drain();
    set_window(0, 7, 8, 15);
    send_request(bdcp_pkg::OP_COMPUTE, 5'd0, 32'h0, 32'h0, 32'h0);
    drain();
    set_window(3, 2, 5, 4);
    send_request(bdcp_pkg::OP_COMPUTE, 5'd0, 32'h0, 32'h0, 32'h0);
    drain();
    set_window(3, 2, 0, 8);
    send_request(bdcp_pkg::OP_COMPUTE, 5'd0, 32'h0, 32'h0, 32'h0);
    drain();

    // Random part in three idling phases; mostly small windows.
    for (phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 59 : 0;
      for (int n = 0; n < 55; n++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          send_request(bdcp_pkg::OP_LOAD_POINT, 5'($urandom_range(0, 17)), rand_coord(),
                       rand_coord(), rand_coord());
        end else if (pick < 70) begin
          send_request(bdcp_pkg::OP_LOAD_KNOT, 5'($urandom_range(0, 31)),
                       rand_knot($urandom_range(31)), $urandom, $urandom);
        end else if (pick < 73) begin
          send_request(OP_RESERVED, 5'($urandom), $urandom, $urandom, $urandom);
        end else begin
          drain();
          fp = $urandom_range(0, 15);
          if ($urandom_range(9) == 0) lp = $urandom_range(0, 15);
          else if ($urandom_range(4) == 0) lp = fp + 7;
          else lp = fp + $urandom_range(0, 3);
          if (lp > 15) lp = 15;
          set_window($urandom_range(0, 7), $urandom_range(0, 7), fp, lp);
          send_request(bdcp_pkg::OP_COMPUTE, 5'($urandom), $urandom, $urandom, $urandom);
        end
      end
      drain();
    end

    drain();
    $display("Ran %0d requests (loads, computes, ignored codes), checked %0d entries",
             request_count, entry_count);
    $display("Windows from single points to eight, degrees 0..7, all idling phases");
    if (error_count == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d entries missing", error_count, sb.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
